>>> design/vsu_pkg.sv
// ----------------------------------------------------------------------------
// vsu_pkg
// Shared types and constants of the vehicle speed update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vsu_pkg;

	// speed mode codes, signed 3 bit
	localparam logic [2:0] MODE_GAS   = 3'b010;
	localparam logic [2:0] MODE_ACCEL = 3'b001;
	localparam logic [2:0] MODE_HOLD  = 3'b000;
	localparam logic [2:0] MODE_DECEL = 3'b111;
	localparam logic [2:0] MODE_BRAKE = 3'b110;

	// emergency levels
	localparam logic [1:0] EMER_NONE = 2'd0;
	localparam logic [1:0] EMER_LOW  = 2'd1;
	localparam logic [1:0] EMER_MID  = 2'd2;
	localparam logic [1:0] EMER_HIGH = 2'd3;

	// acceleration in units of 1/200 m/s2 times 3.6
	localparam int unsigned KW = 13;
	localparam logic [KW-1:0] K_ACCEL     = 13'd720;
	localparam logic [KW-1:0] K_DECEL     = 13'd2160;
	localparam logic [KW-1:0] K_EMER_LOW  = 13'd2160;
	localparam logic [KW-1:0] K_EMER_MID  = 13'd2592;
	localparam logic [KW-1:0] K_EMER_HIGH = 13'd4320;

	// 2e11 = 2^12 * 5^11; odd part divided by reciprocal
	localparam int unsigned DIV_SHIFT = 12;
	localparam int unsigned DIVW      = 26;
	localparam logic [DIVW-1:0] DIV_ODD = 26'd48828125;
	localparam int unsigned RECW      = 25;
	localparam longint unsigned RECIP_FULL = (64'd1 << 50) / 64'd48828125;
	localparam logic [RECW-1:0] RECIP = RECW'(RECIP_FULL);

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LIMIT_ENABLE = 1'b0;
	localparam cfg_idx_t CFG_LIMIT_SPEED  = 1'b1;

	// per item side information that rides along the pipeline
	typedef struct packed {
		logic [15:0] cur;
		logic        hold;
		logic        neg;
		logic        rev;
		logic        mode12;
	} ctl_t;

endpackage

`default_nettype wire

>>> design/vehicle_speed_update.sv
// ----------------------------------------------------------------------------
// vehicle_speed_update
// Computes the next vehicle speed from speed, mode, pedals and time step.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge where start is high and busy is low.
//   busy stays low: the pipeline takes one item every cycle.
//   done pulses for one cycle with new_speed valid once the item has passed
//   stages s1 to s8; results leave in the order items came in.
//   Throughput is one item per cycle; the datapath has eight stages
//   (pedal scaling, time multiply, reciprocal multiply, back multiply,
//   remainder, correction, sum, clamp and limit).
//   The receiver has no stall; every done word must be taken as it comes.
//   limit_enable (index 0) and limit_speed (index 1) are written through
//   cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high. The user
//   must make writes only while no item is in flight; the block does not enforce it.
//   Reset (arst_n low) clears all stage valid bits and both registers;
//   items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_speed_update #(
	parameter int SPEED_FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] current_speed,
	input  wire logic [2:0]  speed_mode,
	input  wire logic [1:0]  emergency_level,
	input  wire logic [9:0]  gas_pedal,
	input  wire logic [9:0]  brake_pedal,
	input  wire logic        reverse_gear,
	input  wire logic [29:0] elapsed_ns,
	output logic             done,
	output logic [15:0]      new_speed,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int F   = SPEED_FRAC_BITS;
	localparam int KW  = vsu_pkg::KW;
	localparam int TW  = 30;
	localparam int XW  = KW + TW;
	localparam int YW  = XW + F - vsu_pkg::DIV_SHIFT;
	localparam int YHW = YW - 24;
	localparam int QW  = YW - 25;
	localparam int PW  = QW + vsu_pkg::DIVW;
	localparam int RW  = vsu_pkg::DIVW + 1;
	localparam int SW  = (((8 + F) > 16) ? (8 + F) : 16) + 2;
	localparam logic signed [SW-1:0] FWD_MAX = SW'(longint'(250) << F);
	localparam logic signed [SW-1:0] REV_MAX = SW'(longint'(20) << F);

	logic accept;
	logic limit_en_q;
	logic [15:0] limit_speed_q;

	logic fwd_emer, mode_is_hold;
	logic [KW-1:0] k_c;
	vsu_pkg::ctl_t ctl_c;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              valid_s5, valid_s6, valid_s7, valid_s8;
	vsu_pkg::ctl_t     ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [KW-1:0]     k_s1;
	logic [TW-1:0]     t_s1;
	logic [XW-1:0]     x_s2;
	logic [YW-1:0]     y_s3, y_s4;
	logic [QW-1:0]     q_s3, q_s4, q_s5;
	logic [YW-1:0]     p_s4;
	logic [RW-1:0]     r_s5;
	logic [QW-1:0]     delta_s6;
	logic signed [SW-1:0] sum_s7;
	logic [15:0]       speed_s8;

	logic [YW-1:0]     y_c;
	logic [YHW+vsu_pkg::RECW-1:0] m3_c;
	logic [PW-1:0]     p_c;
	logic [YW-1:0]     diff_c;
	logic [SW-1:0]     cur_ext, delta_ext;
	logic signed [SW-1:0] res_c;
	logic [15:0]       speed_c;

	assign accept    = start && !busy;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_en_q    <= 1'b0;
			limit_speed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vsu_pkg::CFG_LIMIT_ENABLE: limit_en_q    <= cfg_data[0];
				vsu_pkg::CFG_LIMIT_SPEED:  limit_speed_q <= cfg_data;
				default:                   limit_en_q    <= limit_en_q;
			endcase
		end
	end

	// acceleration select
	always_comb begin
		fwd_emer     = !reverse_gear && (emergency_level != vsu_pkg::EMER_NONE);
		mode_is_hold = (speed_mode == vsu_pkg::MODE_HOLD);
		k_c          = '0;
		ctl_c.cur    = current_speed;
		ctl_c.rev    = reverse_gear;
		ctl_c.mode12 = (speed_mode == vsu_pkg::MODE_GAS) ||
			(speed_mode == vsu_pkg::MODE_ACCEL);
		ctl_c.hold   = !fwd_emer && mode_is_hold;
		ctl_c.neg    = 1'b0;
		priority if (fwd_emer) begin
			ctl_c.neg = 1'b1;
			unique case (emergency_level)
				vsu_pkg::EMER_LOW:  k_c = vsu_pkg::K_EMER_LOW;
				vsu_pkg::EMER_MID:  k_c = vsu_pkg::K_EMER_MID;
				vsu_pkg::EMER_HIGH: k_c = vsu_pkg::K_EMER_HIGH;
				default:            k_c = '0;
			endcase
		end else if (speed_mode == vsu_pkg::MODE_GAS) begin
			k_c = KW'(gas_pedal) * KW'(3);
		end else if (speed_mode == vsu_pkg::MODE_ACCEL) begin
			k_c = vsu_pkg::K_ACCEL;
		end else if (speed_mode == vsu_pkg::MODE_DECEL) begin
			k_c       = vsu_pkg::K_DECEL;
			ctl_c.neg = 1'b1;
		end else if (speed_mode == vsu_pkg::MODE_BRAKE) begin
			k_c       = KW'(brake_pedal) * KW'(6);
			ctl_c.neg = 1'b1;
		end else begin
			k_c = '0;
		end
	end

	// datapath arithmetic between stages
	always_comb begin
		y_c       = YW'({x_s2, {F{1'b0}}} >> vsu_pkg::DIV_SHIFT);
		m3_c      = y_c[YW-1:24] * vsu_pkg::RECIP;
		p_c       = q_s3 * vsu_pkg::DIV_ODD;
		diff_c    = y_s4 - p_s4;
		cur_ext   = SW'(ctl_s6.cur);
		delta_ext = SW'(delta_s6);
	end

	// clamp and limit
	always_comb begin
		priority if (ctl_s7.rev) begin
			if (sum_s7[SW-1])
				res_c = '0;
			else if (sum_s7 > REV_MAX)
				res_c = REV_MAX;
			else
				res_c = sum_s7;
		end else if (sum_s7[SW-1]) begin
			res_c = '0;
		end else if (sum_s7 > FWD_MAX) begin
			res_c = FWD_MAX;
		end else begin
			res_c = sum_s7;
			if (limit_en_q && ctl_s7.mode12 && (res_c > $signed(SW'(limit_speed_q))))
				res_c = $signed(SW'(limit_speed_q));
		end
		speed_c = ctl_s7.hold ? ctl_s7.cur : res_c[15:0];
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		ctl_s1   <= ctl_c;
		k_s1     <= k_c;
		t_s1     <= elapsed_ns;

		ctl_s2   <= ctl_s1;
		x_s2     <= XW'(k_s1) * XW'(t_s1);

		ctl_s3   <= ctl_s2;
		y_s3     <= y_c;
		q_s3     <= m3_c[YHW+vsu_pkg::RECW-1:26];

		ctl_s4   <= ctl_s3;
		y_s4     <= y_s3;
		q_s4     <= q_s3;
		p_s4     <= p_c[YW-1:0];

		ctl_s5   <= ctl_s4;
		q_s5     <= q_s4;
		r_s5     <= diff_c[RW-1:0];

		ctl_s6   <= ctl_s5;
		delta_s6 <= q_s5 + QW'(r_s5 >= RW'(vsu_pkg::DIV_ODD));

		ctl_s7   <= ctl_s6;
		sum_s7   <= $signed(ctl_s6.neg ? (cur_ext - delta_ext) : (cur_ext + delta_ext));

		speed_s8 <= speed_c;
	end

	assign done      = valid_s8;
	assign new_speed = speed_s8;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##8 done)
		else $error("item accepted without result eight cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 8))
		else $error("result without matching accepted item");

	a_recip_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (r_s5 < {vsu_pkg::DIV_ODD, 1'b0}))
		else $error("reciprocal quotient off by more than one");

	a_fwd_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !ctl_s7.neg |-> !sum_s7[SW-1])
		else $error("forward speed sum went negative");

endmodule

`default_nettype wire

>>> test/tb_vehicle_speed_update.sv
// ----------------------------------------------------------------------------
// tb_vehicle_speed_update
// Drives speed update words through the pipeline. A directed table covers
// hold, clamping, unknown modes, emergency and limit cases, and random words
// follow under several limit settings. Every done word is checked against
// an in-order queue filled by a local next speed calculation or by the typed row value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vehicle_speed_update;

	localparam int SPEED_FRAC_BITS = 8;
	localparam int PIPE_DEPTH = 8;
	localparam longint FWD_TOP = 250 << SPEED_FRAC_BITS;
	localparam longint REV_TOP = 20 << SPEED_FRAC_BITS;

	// codes outside the defined speed modes
	localparam logic [2:0] MODE_BAD_P3 = 3'b011;
	localparam logic [2:0] MODE_BAD_M3 = 3'b101;
	localparam logic [2:0] MODE_BAD_M4 = 3'b100;

	typedef struct packed {
		logic        lim_on;
		logic [15:0] lim_kmh;
		logic        typed;
		logic [15:0] want;
		logic [15:0] cur;
		logic [2:0]  mode;
		logic [1:0]  emer;
		logic [9:0]  gas;
		logic [9:0]  brake;
		logic        rev;
		logic [29:0] ns;
	} speed_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] current_speed = '0;
	logic [2:0]  speed_mode = vsu_pkg::MODE_HOLD;
	logic [1:0]  emergency_level = vsu_pkg::EMER_NONE;
	logic [9:0]  gas_pedal = '0;
	logic [9:0]  brake_pedal = '0;
	logic        reverse_gear = 1'b0;
	logic [29:0] elapsed_ns = '0;
	logic        done;
	logic [15:0] new_speed;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	vsu_pkg::cfg_idx_t cfg_index = vsu_pkg::CFG_LIMIT_ENABLE;
	logic [15:0] cfg_data = '0;

	logic        row_typed = 1'b0;
	logic [15:0] row_want = '0;

	logic        limit_on = 1'b0;
	logic [15:0] limit_kmh = '0;
	logic [15:0] pending_speeds [$];
	logic [15:0] want_speed;
	int unsigned mismatches = 0;
	int unsigned calm = 0;

	vehicle_speed_update #(.SPEED_FRAC_BITS(SPEED_FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.current_speed(current_speed),
		.speed_mode(speed_mode),
		.emergency_level(emergency_level),
		.gas_pedal(gas_pedal),
		.brake_pedal(brake_pedal),
		.reverse_gear(reverse_gear),
		.elapsed_ns(elapsed_ns),
		.done(done),
		.new_speed(new_speed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	speed_req_t dir_rows [25] = '{
		'{1'b0, 16'd0, 1'b1, 16'd12345, 16'd12345, vsu_pkg::MODE_HOLD,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b1, 16'hFFFF, 16'hFFFF, vsu_pkg::MODE_HOLD,
			vsu_pkg::EMER_HIGH, 10'd0, 10'd0, 1'b1, 30'h3FFFFFFF},
		'{1'b0, 16'd0, 1'b1, 16'd64000, 16'hFFFF, vsu_pkg::MODE_ACCEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd0},
		'{1'b0, 16'd0, 1'b1, 16'd0, 16'd0, vsu_pkg::MODE_DECEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b1, 16'd5120, 16'hFFFF, MODE_BAD_P3,
			vsu_pkg::EMER_NONE, 10'h3FF, 10'h3FF, 1'b1, 30'h3FFFFFFF},
		'{1'b0, 16'd0, 1'b1, 16'd100, 16'd100, MODE_BAD_M3,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b1, 16'd64000, 16'hFFFF, MODE_BAD_M4,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b1, 16'd1000, 16'd1000, vsu_pkg::MODE_HOLD,
			vsu_pkg::EMER_LOW, 10'd0, 10'd0, 1'b1, 30'd1000000000},
		'{1'b0, 16'd0, 1'b1, 16'd0, 16'd0, vsu_pkg::MODE_HOLD,
			vsu_pkg::EMER_HIGH, 10'd0, 10'd0, 1'b0, 30'h3FFFFFFF},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd64000, vsu_pkg::MODE_HOLD,
			vsu_pkg::EMER_HIGH, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd64000, vsu_pkg::MODE_GAS,
			vsu_pkg::EMER_MID, 10'd720, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd0, vsu_pkg::MODE_GAS,
			vsu_pkg::EMER_NONE, 10'd720, 10'd0, 1'b0, 30'h3FFFFFFF},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd1000, vsu_pkg::MODE_GAS,
			vsu_pkg::EMER_NONE, 10'h3FF, 10'd0, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd64000, vsu_pkg::MODE_BRAKE,
			vsu_pkg::EMER_NONE, 10'd0, 10'h3FF, 1'b0, 30'd1000000000},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd30000, vsu_pkg::MODE_BRAKE,
			vsu_pkg::EMER_NONE, 10'd0, 10'd720, 1'b0, 30'd1},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd5000, vsu_pkg::MODE_ACCEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b1, 30'd1000000000},
		'{1'b0, 16'd0, 1'b1, 16'd5120, 16'd5100, vsu_pkg::MODE_GAS,
			vsu_pkg::EMER_NONE, 10'h3FF, 10'd0, 1'b1, 30'h3FFFFFFF},
		'{1'b0, 16'd0, 1'b1, 16'd0, 16'd100, vsu_pkg::MODE_BRAKE,
			vsu_pkg::EMER_NONE, 10'd0, 10'h3FF, 1'b1, 30'h3FFFFFFF},
		'{1'b0, 16'd0, 1'b0, 16'd0, 16'd40000, vsu_pkg::MODE_DECEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd500000000},
		'{1'b1, 16'd2560, 1'b0, 16'd0, 16'd2500, vsu_pkg::MODE_ACCEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b1, 16'd2560, 1'b1, 16'd2560, 16'd5000, vsu_pkg::MODE_ACCEL,
			vsu_pkg::EMER_LOW, 10'd0, 10'd0, 1'b0, 30'd100000000},
		'{1'b1, 16'd2560, 1'b0, 16'd0, 16'd5000, vsu_pkg::MODE_DECEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd100000000},
		'{1'b1, 16'd2560, 1'b1, 16'd64000, 16'hFFFF, vsu_pkg::MODE_GAS,
			vsu_pkg::EMER_NONE, 10'd720, 10'd0, 1'b0, 30'd0},
		'{1'b1, 16'd0, 1'b1, 16'd0, 16'd100, vsu_pkg::MODE_GAS,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'd1000000000},
		'{1'b1, 16'hFFFF, 1'b0, 16'd0, 16'd63000, vsu_pkg::MODE_ACCEL,
			vsu_pkg::EMER_NONE, 10'd0, 10'd0, 1'b0, 30'h3FFFFFFF}
	};

	function automatic logic [15:0] next_speed(input logic [15:0] cur, input logic [2:0] mode,
			input logic [1:0] emer, input logic [9:0] gas, input logic [9:0] brake,
			input logic rev, input logic [29:0] ns);
		longint unsigned k;
		longint unsigned delta;
		longint sum;
		longint res;
		logic slowing;
		k = 0;
		slowing = 1'b0;
		if (!rev && emer != vsu_pkg::EMER_NONE) begin
			slowing = 1'b1;
			case (emer)
				vsu_pkg::EMER_LOW: k = vsu_pkg::K_EMER_LOW;
				vsu_pkg::EMER_MID: k = vsu_pkg::K_EMER_MID;
				default: k = vsu_pkg::K_EMER_HIGH;
			endcase
		end else if (mode == vsu_pkg::MODE_HOLD) begin
			return cur;
		end else begin
			case (mode)
				vsu_pkg::MODE_GAS: k = 3 * gas;
				vsu_pkg::MODE_ACCEL: k = vsu_pkg::K_ACCEL;
				vsu_pkg::MODE_DECEL: begin
					k = vsu_pkg::K_DECEL;
					slowing = 1'b1;
				end
				vsu_pkg::MODE_BRAKE: begin
					k = 6 * brake;
					slowing = 1'b1;
				end
				default: k = 0;
			endcase
		end
		// speed change in output lsbs, truncated toward zero
		delta = (k * 64'(ns) * (64'd1 << SPEED_FRAC_BITS)) / 64'd200000000000;
		sum = slowing ? longint'(cur) - longint'(delta) : longint'(cur) + longint'(delta);
		if (!rev && sum >= 0 && sum <= FWD_TOP) begin
			res = sum;
			if (limit_on && res > limit_kmh &&
					(mode == vsu_pkg::MODE_ACCEL || mode == vsu_pkg::MODE_GAS))
				res = limit_kmh;
		end else if (sum < 0) begin
			res = 0;
		end else begin
			res = rev ? (sum > REV_TOP ? REV_TOP : sum) : FWD_TOP;
		end
		return res[15:0];
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_speeds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word new_speed=%0d", $realtime, new_speed);
				end else begin
					want_speed = pending_speeds.pop_front();
					if (new_speed !== want_speed) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: new_speed expected %0d got %0d", $realtime,
								want_speed, new_speed);
					end
				end
			end
			if (start && !busy)
				pending_speeds.push_back(row_typed ? row_want :
					next_speed(current_speed, speed_mode, emergency_level, gas_pedal,
						brake_pedal, reverse_gear, elapsed_ns));
		end
	end

	task automatic send_req(input speed_req_t r);
		start <= 1'b1;
		current_speed <= r.cur;
		speed_mode <= r.mode;
		emergency_level <= r.emer;
		gas_pedal <= r.gas;
		brake_pedal <= r.brake;
		reverse_gear <= r.rev;
		elapsed_ns <= r.ns;
		row_typed <= r.typed;
		row_want <= r.want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait until every word has come back and the pipeline is empty
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_speeds.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic set_limits(input logic en, input logic [15:0] kmh);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= vsu_pkg::CFG_LIMIT_ENABLE;
		cfg_data <= {15'd0, en};
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		limit_on = en;
		cfg_index <= vsu_pkg::CFG_LIMIT_SPEED;
		cfg_data <= kmh;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		limit_kmh = kmh;
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (roll < 3)
			calm = $urandom_range(10, 40);
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic speed_req_t random_req();
		speed_req_t r;
		int unsigned lo;
		r = '0;
		lo = (limit_kmh > 300) ? limit_kmh - 300 : 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: r.cur = 16'($urandom_range(0, 64000));
			5: r.cur = 16'($urandom);
			6, 7: r.cur = 16'($urandom_range(lo, lo + 600));
			8: begin
				case ($urandom_range(0, 2))
					0: r.cur = 16'($urandom_range(0, 40));
					1: r.cur = 16'($urandom_range(5100, 5140));
					default: r.cur = 16'($urandom_range(63980, 64020));
				endcase
			end
			default: r.cur = 16'($urandom_range(60000, 65535));
		endcase
		if ($urandom_range(0, 6) == 0) begin
			r.mode = 3'($urandom);
		end else begin
			case ($urandom_range(0, 4))
				0: r.mode = vsu_pkg::MODE_GAS;
				1: r.mode = vsu_pkg::MODE_ACCEL;
				2: r.mode = vsu_pkg::MODE_HOLD;
				3: r.mode = vsu_pkg::MODE_DECEL;
				default: r.mode = vsu_pkg::MODE_BRAKE;
			endcase
		end
		r.emer = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : vsu_pkg::EMER_NONE;
		r.gas = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 720));
		r.brake = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 720));
		r.rev = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: r.ns = 30'($urandom_range(0, 1000000000));
			4, 5: r.ns = 30'($urandom);
			6, 7, 8: r.ns = 30'($urandom_range(0, 20000000));
			default: r.ns = 30'($urandom_range(0, 2000));
		endcase
		return r;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_limits(1'b0, 16'd0);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].lim_on != limit_on || dir_rows[i].lim_kmh != limit_kmh)
				set_limits(dir_rows[i].lim_on, dir_rows[i].lim_kmh);
			send_req(dir_rows[i]);
			pause(pick_gap());
		end
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_limits(1'b0, 16'd0);
				1: set_limits(1'b1, 16'd0);
				2: set_limits(1'b1, 16'd64000);
				3: set_limits(1'b1, 16'($urandom_range(0, 64000)));
				4: set_limits(1'b1, 16'hFFFF);
				5: set_limits(1'b1, 16'($urandom_range(0, 64000)));
				default: set_limits(1'b0, 16'($urandom));
			endcase
			for (int n = 0; n < 136; n++) begin
				send_req(random_req());
				if ($urandom_range(0, 149) == 0)
					settle();
				else
					pause(pick_gap());
			end
		end
		settle();
		if (mismatches == 0)
			$display("tb_vehicle_speed_update OK");
		else
			$display("tb_vehicle_speed_update NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_vehicle_speed_update NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
